// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ZB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent assertion on the default clock and reset of this project
`define ZB_ASSERT(lbl, prop, msg) \
  `ZB_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/zb32_pkg.sv =====
// ----------------------------------------------------------------------------
// zb32_pkg
// shared types, constants and the alphabet lookup of the zbase32 encoder
// ----------------------------------------------------------------------------
package zb32_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned SymW     = 5;
  localparam int unsigned CharW    = 7;
  localparam int unsigned CntW     = 2;
  localparam int unsigned QueueDepthDef = 2;

  // alphabet, first character in the top byte
  localparam logic [255:0] AlphabetStr = "ybndrfg8ejkmcpqxot1uwisza345h769";

  // packing phase, one-hot
  typedef enum logic [4:0] {
    PH0 = 5'b00001,
    PH1 = 5'b00010,
    PH2 = 5'b00100,
    PH3 = 5'b01000,
    PH4 = 5'b10000
  } phase_e;

  // one classified word: up to three symbols and their count
  typedef struct packed {
    logic [SymW-1:0] sym0;
    logic [SymW-1:0] sym1;
    logic [SymW-1:0] sym2;
    logic [CntW-1:0] count;
    logic            last;
  } job_t;

  // symbol value to ascii code
  function automatic logic [CharW-1:0] sym_to_char(input logic [SymW-1:0] sym);
    logic [7:0] base;
    base = 8'(8 * (31 - int'(sym)));
    return AlphabetStr[base +: CharW];
  endfunction

endpackage

// ===== hdl/zb32_front.sv =====
// ----------------------------------------------------------------------------
// zb32_front
// accepts input bytes, tracks the packing phase and leftover bits, and
// splits each byte into the symbols it completes, plus a flush symbol on a last byte
// ----------------------------------------------------------------------------
module zb32_front
  import zb32_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_last_i,
  input  logic             q_full_i,
  output logic             push_o,
  output job_t             job_o
);

  `include "assert_macros.svh"

  phase_e      phase_q, phase_d;
  logic [3:0]  left_q, left_d;
  logic        accept;
  phase_e      ph_nxt;
  logic [3:0]  lo_nxt;
  logic [11:0] x;
  job_t        job;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // split the byte according to the phase
  always_comb begin
    x      = '0;
    job    = '0;
    ph_nxt = PH0;
    lo_nxt = '0;
    case (phase_q)
      PH1: begin
        x         = {1'b0, in_byte_i, left_q[2:0]};
        job.sym0  = x[4:0];
        job.sym1  = x[9:5];
        job.count = 2'd2;
        lo_nxt    = {3'b000, x[10]};
        ph_nxt    = PH2;
      end
      PH2: begin
        x         = {3'b000, in_byte_i, left_q[0]};
        job.sym0  = x[4:0];
        job.count = 2'd1;
        lo_nxt    = x[8:5];
        ph_nxt    = PH3;
      end
      PH3: begin
        x         = {in_byte_i, left_q[3:0]};
        job.sym0  = x[4:0];
        job.sym1  = x[9:5];
        job.count = 2'd2;
        lo_nxt    = {2'b00, x[11:10]};
        ph_nxt    = PH4;
      end
      PH4: begin
        x         = {2'b00, in_byte_i, left_q[1:0]};
        job.sym0  = x[4:0];
        job.sym1  = x[9:5];
        job.count = 2'd2;
        lo_nxt    = '0;
        ph_nxt    = PH0;
      end
      default: begin
        // start of a five-byte group
        x         = {4'b0000, in_byte_i};
        job.sym0  = x[4:0];
        job.count = 2'd1;
        lo_nxt    = {1'b0, x[7:5]};
        ph_nxt    = PH1;
      end
    endcase
    // flush of waiting bits on the last byte
    job.last = in_last_i;
    if (in_last_i && ph_nxt != PH0) begin
      if (job.count == 2'd1) begin
        job.sym1 = {1'b0, lo_nxt};
      end else begin
        job.sym2 = {1'b0, lo_nxt};
      end
      job.count = job.count + 2'd1;
    end
  end

  // state update
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    if (accept) begin
      phase_d = in_last_i ? PH0 : ph_nxt;
      left_d  = in_last_i ? 4'd0 : lo_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

  assign push_o = accept;
  assign job_o  = job;

  // a last byte always returns the packer to the group start
  `ZB_ASSERT(a_last_resets_phase, accept && in_last_i |=> phase_q == PH0 && left_q == 4'd0, "phase not cleared after last word")

endmodule

// ===== hdl/zb32_queue.sv =====
// ----------------------------------------------------------------------------
// zb32_queue
// short register queue of classified words between front and back
// ----------------------------------------------------------------------------
module zb32_queue
  import zb32_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t head_o
);

  `include "assert_macros.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NumW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [NumW-1:0] DepthN  = NumW'(Depth);

  job_t            entry_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NumW-1:0] num_q, num_d;
  logic            do_push, do_pop;

  assign full_o  = (num_q == DepthN);
  assign valid_o = (num_q != '0);
  assign head_o  = entry_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointer and fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    num_d = num_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      num_d = num_q + 1'b1;
    end else if (do_pop && !do_push) begin
      num_d = num_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      num_q <= num_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= job_i;
    end
  end

  // fill level and pointers agree
  `ZB_ASSERT(a_level_ok, num_q <= DepthN && (num_q == DepthN || num_q == '0 || wr_q != rd_q), "queue level and pointers disagree")

endmodule

// ===== hdl/zb32_back.sv =====
// ----------------------------------------------------------------------------
// zb32_back
// walks the symbols of the head word one per cycle into the output register unless the output stalls
// ----------------------------------------------------------------------------
module zb32_back
  import zb32_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  job_t             head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] out_char_o,
  output logic             out_last_o
);

  `include "assert_macros.svh"

  logic [CntW-1:0]  idx_q, idx_d;
  logic             vld_q, vld_d;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             take, emit, final_sym;
  logic [SymW-1:0]  sym;

  assign take      = ~vld_q | out_ready_i;
  assign emit      = head_valid_i & take;
  assign final_sym = (idx_q == head_i.count - 2'd1);
  assign pop_o     = emit & final_sym;

  // symbol selection
  always_comb begin
    case (idx_q)
      2'd0:    sym = head_i.sym0;
      2'd1:    sym = head_i.sym1;
      default: sym = head_i.sym2;
    endcase
  end

  // symbol index and output valid
  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q & ~out_ready_i;
    if (emit) begin
      idx_d = final_sym ? '0 : idx_q + 2'd1;
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      char_q <= sym_to_char(sym);
      last_q <= head_i.last & final_sym;
    end
  end

  assign out_valid_o = vld_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  // the symbol index never runs past the head word
  `ZB_ASSERT(a_idx_in_range, head_valid_i |-> idx_q < head_i.count, "symbol index beyond word")

endmodule

// ===== hdl/lsb_first_zbase32_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// lsb_first_zbase32_encoder_unit
// least-significant-first zbase32 encoder, one byte in, ascii characters out
// ----------------------------------------------------------------------------
// Each input byte gives one or two characters, plus one flush character
// when it is marked last and bits are still waiting; a five-byte group
// gives eight characters. The output side delivers one character per
// clock while m_axis_tready does not stall it. The input is taken every
// cycle while the word queue (QueueDepth entries) has room. When the
// back end is idle, the word of an accepted byte is written into the
// queue and its first character then into the output register that
// drives m_axis_tvalid. No clearing pass is needed after reset.
module lsb_first_zbase32_encoder_unit
  import zb32_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,  // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [6:0] symbol_char, [7] zero
  output logic       m_axis_tlast   // last_symbol
);

  logic             push, pop, q_full, q_valid;
  job_t             job, head;
  logic [CharW-1:0] out_char;

  // front: phase tracking and symbol split
  zb32_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job)
  );

  // word queue
  zb32_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  // back: one character per cycle unless m_axis_tready stalls it
  zb32_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (out_char),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule
